FILE: rtl/shd_pkg.sv
// shared types and constants for the header deframer
`default_nettype none
package shd_pkg;

  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned POS_W     = 33;

  localparam logic [7:0] VERSION_RESET = 8'd1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_WRONG_VER = 2'd2;
  localparam logic [1:0] STATUS_TRUNC     = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [15:0] service;
    logic [15:0] method;
    logic [31:0] length;
    logic [15:0] client;
    logic [15:0] session;
    logic [7:0]  if_version;
    logic [7:0]  msg_type;
    logic [7:0]  return_code;
  } shd_header_t;

  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload;
    logic        has_status;
    logic [1:0]  status;
    shd_header_t hdr;
  } shd_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/shd_front.sv
// front part: byte counting, header capture, version check, classification
`default_nettype none
module shd_front
  import shd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  input  wire logic       q_full,
  output logic            q_push,
  output shd_cmd_t        q_cmd
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] seen;
  logic [7:0]       hdr [HDR_BYTES];
  logic [7:0]       hdr_now [HDR_BYTES];
  logic             version_bad;
  logic             version_bad_now;
  logic [7:0]       expected_version;
  logic             accept;
  logic             pos_hdr;
  logic [3:0]       idx;
  logic [31:0]      len_stored;
  logic [31:0]      len_now;
  logic [POS_W:0]   end_stored;
  logic [POS_W:0]   end_now;
  logic             in_payload;
  logic [1:0]       status;

  assign accept  = push && !q_full;
  assign pos_hdr = (pos[POS_W-1:4] == '0);
  assign idx     = pos[3:0];

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_now[i] = (pos_hdr && (idx == 4'(i))) ? data_byte : hdr[i];
    end
  end

  assign len_stored = {hdr[4], hdr[5], hdr[6], hdr[7]};
  assign len_now    = {hdr_now[4], hdr_now[5], hdr_now[6], hdr_now[7]};
  assign end_stored = {2'b00, len_stored} + (POS_W+1)'(HDR_BYTES);
  assign end_now    = {2'b00, len_now} + (POS_W+1)'(HDR_BYTES);

  assign seen = (pos == '1) ? pos : pos + POS_W'(1);

  assign version_bad_now = (pos_hdr && (idx == 4'd12)) ? (data_byte != expected_version)
                                                        : version_bad;

  assign in_payload = !pos_hdr && !version_bad && ({1'b0, pos} < end_stored);

  always_comb begin
    priority if (pos_hdr && (idx != 4'd15)) begin
      status = STATUS_SHORT;
    end else if (version_bad_now) begin
      status = STATUS_WRONG_VER;
    end else if ({1'b0, seen} < end_now) begin
      status = STATUS_TRUNC;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    q_cmd.has_payload     = in_payload;
    q_cmd.payload         = data_byte;
    q_cmd.has_status      = last_byte;
    q_cmd.status          = status;
    q_cmd.hdr.service     = {hdr_now[0], hdr_now[1]};
    q_cmd.hdr.method      = {hdr_now[2], hdr_now[3]};
    q_cmd.hdr.length      = len_now;
    q_cmd.hdr.client      = {hdr_now[8], hdr_now[9]};
    q_cmd.hdr.session     = {hdr_now[10], hdr_now[11]};
    q_cmd.hdr.if_version  = hdr_now[13];
    q_cmd.hdr.msg_type    = hdr_now[14];
    q_cmd.hdr.return_code = hdr_now[15];
  end

  assign q_push = accept && (in_payload || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
    end else if (cfg_write) begin
      expected_version <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      version_bad <= 1'b0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr[i] <= '0;
      end
    end else if (accept) begin
      if (last_byte) begin
        pos         <= '0;
        version_bad <= 1'b0;
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr[i] <= '0;
        end
      end else begin
        pos         <= seen;
        version_bad <= version_bad_now;
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr[i] <= hdr_now[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/shd_queue.sv
// short queue of classified items between front and back
`default_nettype none
module shd_queue
  import shd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  wire shd_cmd_t wr_cmd,
  input  wire logic     rd,
  output shd_cmd_t      head,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  shd_cmd_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/shd_back.sv
// back part: expands queued items into result items, output register
`default_nettype none
module shd_back
  import shd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire shd_cmd_t head,
  input  wire logic     q_empty,
  output logic          q_pop,
  input  wire logic     pop,
  output logic          empty,
  output logic          result_kind,
  output logic [7:0]    payload_byte,
  output logic [1:0]    frame_status,
  output logic [15:0]   service_field,
  output logic [15:0]   method_field,
  output logic [31:0]   length_field,
  output logic [15:0]   client_field,
  output logic [15:0]   session_field,
  output logic [7:0]    interface_version_field,
  output logic [7:0]    type_field,
  output logic [7:0]    return_code_field,
  output logic          last_of_run
);

  logic out_valid;
  logic payload_done;
  logic load;
  logic take_payload;

  assign empty        = !out_valid;
  assign load         = !out_valid || pop;
  assign take_payload = head.has_payload && !payload_done;
  assign q_pop        = load && !q_empty && !(take_payload && head.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      payload_done <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        payload_done <= take_payload && head.has_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (take_payload) begin
        result_kind             <= KIND_PAYLOAD;
        payload_byte            <= head.payload;
        frame_status            <= STATUS_OK;
        service_field           <= '0;
        method_field            <= '0;
        length_field            <= '0;
        client_field            <= '0;
        session_field           <= '0;
        interface_version_field <= '0;
        type_field              <= '0;
        return_code_field       <= '0;
        last_of_run             <= !head.has_status;
      end else begin
        result_kind             <= KIND_STATUS;
        payload_byte            <= '0;
        frame_status            <= head.status;
        service_field           <= head.hdr.service;
        method_field            <= head.hdr.method;
        length_field            <= head.hdr.length;
        client_field            <= head.hdr.client;
        session_field           <= head.hdr.session;
        interface_version_field <= head.hdr.if_version;
        type_field              <= head.hdr.msg_type;
        return_code_field       <= head.hdr.return_code;
        last_of_run             <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/someip_header_deframer_unit.sv
// top level of the header deframer: front, item queue and back
// Input channel: push/full carries one frame byte per item with a last-byte
// marker. Result channel: empty/pop; the oldest result sits on the result
// ports while empty is low. Each byte gives zero, one or two results: a
// payload byte (result_kind 0) and, on the last byte, a status item with the
// header fields (result_kind 1). cfg_write/cfg_data set the expected protocol
// version (reset value 1), taken when byte 12 of a frame arrives.
// A result passes through a queue slot and then the output register to reach the
// ports; a byte's status item comes after its payload item, if it has one.
// Throughput: one byte per cycle while full is low and one result per cycle while
// pop is held; a byte that makes two results holds the back for both, absorbed
// by the queue of QUEUE_DEPTH items between front and back.
// Reset clears the byte counter, captured header, version flag, queue and
// output register, and sets the expected version to 1.
// When the receiver stalls, the output register holds its item, the queue
// fills, and full rises; nothing is lost.
`default_nettype none
module someip_header_deframer_unit
  import shd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind,
  output logic [7:0]       payload_byte,
  output logic [1:0]       frame_status,
  output logic [15:0]      service_field,
  output logic [15:0]      method_field,
  output logic [31:0]      length_field,
  output logic [15:0]      client_field,
  output logic [15:0]      session_field,
  output logic [7:0]       interface_version_field,
  output logic [7:0]       type_field,
  output logic [7:0]       return_code_field,
  output logic             last_of_run
);

  shd_cmd_t q_cmd;
  shd_cmd_t q_head;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  assign full = q_full;

  shd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  shd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_cmd (q_cmd),
    .rd     (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  shd_back u_back (
    .clk                     (clk),
    .rst                     (rst),
    .head                    (q_head),
    .q_empty                 (q_empty),
    .q_pop                   (q_pop),
    .pop                     (pop),
    .empty                   (empty),
    .result_kind             (result_kind),
    .payload_byte            (payload_byte),
    .frame_status            (frame_status),
    .service_field           (service_field),
    .method_field            (method_field),
    .length_field            (length_field),
    .client_field            (client_field),
    .session_field           (session_field),
    .interface_version_field (interface_version_field),
    .type_field              (type_field),
    .return_code_field       (return_code_field),
    .last_of_run             (last_of_run)
  );

endmodule
`default_nettype wire
